// File: rtl/core/cbrp_pkg.sv
// Shared types and constants for the capability bitmap response parser.
// Holds the item structs, the command passed from front to back, and the codes.
// No dependencies.
package cbrp_pkg;

  // Default sizes
  localparam int CAP_WORDS_DEF    = 8;
  localparam int HEADER_BYTES_DEF = 2;
  localparam int MAX_COUNT_DEF    = 32;
  localparam int QUEUE_DEPTH      = 2;

  // Item operations
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_READ = 1'b1;

  // Parse status codes
  localparam logic [2:0] ST_IDLE      = 3'd0;
  localparam logic [2:0] ST_BUSY      = 3'd1;
  localparam logic [2:0] ST_DONE      = 3'd2;
  localparam logic [2:0] ST_BAD_COUNT = 3'd3;
  localparam logic [2:0] ST_BAD_LEN   = 3'd4;

  // Capabilities 3, 7, 9 and 10, forced on at normal completion
  localparam logic [31:0] FORCE_MASK = 32'h0000_0688;

  // Bytes in the little-endian segment start field
  localparam int START_BYTES = 4;

  typedef struct packed {
    logic       op;
    logic [7:0] data_byte;
    logic       frame_start;
    logic [2:0] word_index;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_word;
    logic [7:0]  response_code;
    logic [2:0]  parse_status;
  } out_item_t;

  // One classified item, ready for the bitmap side
  typedef struct packed {
    logic        rd;
    logic [2:0]  word_index;
    logic        clear;
    logic        set_en;
    logic [31:0] base;
    logic [7:0]  bits;
    logic        finish;
    logic [7:0]  response_code;
    logic [2:0]  parse_status;
  } cbrp_cmd_t;

endpackage

// File: rtl/core/cbrp_fifo.sv
// Small register FIFO used between the parser stages and on the result side.
// Depends on nothing; width and depth come from parameters.
module cbrp_fifo #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  entry_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = entry_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed data
  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// File: rtl/core/cbrp_front.sv
// Front end: walks the response framing byte by byte and classifies each item
// into a bitmap command. Depends on cbrp_pkg.
module cbrp_front import cbrp_pkg::*; #(
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_COUNT    = MAX_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      accept,
  input  in_item_t  item,
  output cbrp_cmd_t cmd
);

  localparam int CW  = $clog2(MAX_COUNT + 1);
  localparam int FBW = (HEADER_BYTES > START_BYTES) ? $clog2(HEADER_BYTES + 1) : 3;

  typedef enum logic [6:0] {
    PH_IDLE   = 7'b0000001,
    PH_HEADER = 7'b0000010,
    PH_CODE   = 7'b0000100,
    PH_COUNT  = 7'b0001000,
    PH_START  = 7'b0010000,
    PH_LEN    = 7'b0100000,
    PH_DATA   = 7'b1000000
  } phase_t;

  localparam phase_t FRAME_PH = (HEADER_BYTES > 0) ? PH_HEADER : PH_CODE;

  phase_t         phase_r, phase_nxt, ph;
  logic [FBW-1:0] fbc_r, fbc_nxt, fc, fc_inc;
  logic [CW-1:0]  segs_r, segs_nxt, segs_dec;
  logic [31:0]    seg_start_r, seg_start_nxt;
  logic [CW-1:0]  seg_len_r, seg_len_nxt;
  logic [CW-1:0]  dbi_r, dbi_nxt, dbi_inc;
  logic [7:0]     code_r, code_nxt;
  logic [2:0]     status_r, status_nxt;
  logic [7:0]     b;
  logic           too_big;

  assign b        = item.data_byte;
  assign too_big  = (b > 8'(MAX_COUNT));
  assign ph       = item.frame_start ? FRAME_PH : phase_r;
  assign fc       = item.frame_start ? '0 : fbc_r;
  assign fc_inc   = fc + 1'b1;
  assign dbi_inc  = dbi_r + 1'b1;
  assign segs_dec = (segs_r != '0) ? segs_r - 1'b1 : '0;

  // Classify the item and advance the framing state
  always_comb begin
    phase_nxt     = phase_r;
    fbc_nxt       = fbc_r;
    segs_nxt      = segs_r;
    seg_start_nxt = seg_start_r;
    seg_len_nxt   = seg_len_r;
    dbi_nxt       = dbi_r;
    code_nxt      = code_r;
    status_nxt    = status_r;
    cmd           = '0;
    cmd.rd        = (item.op == OP_READ);
    cmd.word_index = item.word_index;
    cmd.bits      = b;
    cmd.base      = seg_start_r + (32'(dbi_r) << 3);
    if (accept && item.op == OP_PUSH) begin
      phase_nxt = ph;
      fbc_nxt   = fc;
      if (item.frame_start) begin
        status_nxt = ST_BUSY;
      end
      case (ph)
        PH_HEADER: begin
          fbc_nxt = fc_inc;
          if (fc_inc >= FBW'(HEADER_BYTES)) begin
            phase_nxt = PH_CODE;
          end
        end
        PH_CODE: begin
          code_nxt  = b;
          phase_nxt = PH_COUNT;
        end
        PH_COUNT: begin
          cmd.clear = 1'b1;
          if (too_big) begin
            status_nxt = ST_BAD_COUNT;
            phase_nxt  = PH_IDLE;
          end else if (b == 8'd0) begin
            segs_nxt   = '0;
            cmd.finish = 1'b1;
            status_nxt = ST_DONE;
            phase_nxt  = PH_IDLE;
          end else begin
            segs_nxt      = CW'(b);
            phase_nxt     = PH_START;
            fbc_nxt       = '0;
            seg_start_nxt = '0;
          end
        end
        PH_START: begin
          seg_start_nxt = seg_start_r | (32'(b) << {fc[1:0], 3'b000});
          fbc_nxt       = fc_inc;
          if (fc_inc >= FBW'(START_BYTES)) begin
            phase_nxt = PH_LEN;
          end
        end
        PH_LEN: begin
          if (too_big) begin
            status_nxt = ST_BAD_LEN;
            phase_nxt  = PH_IDLE;
          end else if (b == 8'd0) begin
            seg_len_nxt = '0;
            segs_nxt    = segs_dec;
            if (segs_dec == '0) begin
              cmd.finish = 1'b1;
              status_nxt = ST_DONE;
              phase_nxt  = PH_IDLE;
            end else begin
              phase_nxt     = PH_START;
              fbc_nxt       = '0;
              seg_start_nxt = '0;
            end
          end else begin
            seg_len_nxt = CW'(b);
            dbi_nxt     = '0;
            phase_nxt   = PH_DATA;
          end
        end
        PH_DATA: begin
          cmd.set_en = 1'b1;
          dbi_nxt    = dbi_inc;
          if (dbi_inc >= seg_len_r) begin
            segs_nxt = segs_dec;
            if (segs_dec == '0) begin
              cmd.finish = 1'b1;
              status_nxt = ST_DONE;
              phase_nxt  = PH_IDLE;
            end else begin
              phase_nxt     = PH_START;
              fbc_nxt       = '0;
              seg_start_nxt = '0;
            end
          end
        end
        default: begin
          // idle: drop bytes outside a frame
        end
      endcase
    end
    cmd.response_code = code_nxt;
    cmd.parse_status  = status_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      fbc_r       <= '0;
      segs_r      <= '0;
      seg_start_r <= '0;
      seg_len_r   <= '0;
      dbi_r       <= '0;
      code_r      <= '0;
      status_r    <= ST_IDLE;
    end else begin
      phase_r     <= phase_nxt;
      fbc_r       <= fbc_nxt;
      segs_r      <= segs_nxt;
      seg_start_r <= seg_start_nxt;
      seg_len_r   <= seg_len_nxt;
      dbi_r       <= dbi_nxt;
      code_r      <= code_nxt;
      status_r    <= status_nxt;
    end
  end

endmodule

// File: rtl/core/cbrp_back.sv
// Back end: holds the capability bitmap, applies clear/set/force commands in
// order and answers word reads. Depends on cbrp_pkg.
module cbrp_back import cbrp_pkg::*; #(
  parameter int CAP_WORDS = CAP_WORDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  cbrp_cmd_t cmd,
  input  logic      cmd_valid,
  input  logic      res_ready,
  output logic      take,
  output out_item_t res
);

  localparam logic [31:0] CAP_BITS = 32'(32 * CAP_WORDS);

  logic [31:0] bitmap_r   [CAP_WORDS];
  logic [31:0] bitmap_nxt [CAP_WORDS];
  logic [31:0] cap   [8];
  logic [7:0]  hit;
  logic [31:0] rd_word;

  assign take = cmd_valid && res_ready;

  // Capability index of each bit of the byte, and whether it lands in the store
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      cap[k] = cmd.base + 32'(k);
      hit[k] = cmd.set_en && cmd.bits[k] && (cap[k] < CAP_BITS);
    end
  end

  // Clear, then set the byte's bits, then force the fixed capabilities
  always_comb begin
    for (int w = 0; w < CAP_WORDS; w++) begin
      bitmap_nxt[w] = cmd.clear ? 32'd0 : bitmap_r[w];
      for (int k = 0; k < 8; k++) begin
        if (hit[k] && cap[k][31:5] == 27'(w)) begin
          bitmap_nxt[w][cap[k][4:0]] = 1'b1;
        end
      end
      if (cmd.finish && w == 0) begin
        bitmap_nxt[w] = bitmap_nxt[w] | FORCE_MASK;
      end
    end
  end

  // Select the requested word; words beyond the store read as zero
  always_comb begin
    rd_word = 32'd0;
    for (int w = 0; w < CAP_WORDS; w++) begin
      if (32'(cmd.word_index) == 32'(w)) begin
        rd_word = bitmap_r[w];
      end
    end
  end

  assign res.read_word     = cmd.rd ? rd_word : 32'd0;
  assign res.response_code = cmd.response_code;
  assign res.parse_status  = cmd.parse_status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < CAP_WORDS; w++) begin
        bitmap_r[w] <= '0;
      end
    end else if (take) begin
      for (int w = 0; w < CAP_WORDS; w++) begin
        bitmap_r[w] <= bitmap_nxt[w];
      end
    end
  end

endmodule

// File: rtl/core/capability_bitmap_response_parser_top.sv
// Capability bitmap response parser, top level.
// Input queue port: push/full with in_item (op, data_byte, frame_start, word_index).
// A transfer happens at a rising edge with push high and full low.
// Result queue port: empty/pop with out_item (read_word, response_code,
// parse_status); the oldest result shows while empty is low and leaves on a
// transfer with pop high.
// Every input item yields exactly one result, in order. A push op yields a
// zero read_word; a read op returns one bitmap word as of all earlier items.
// The front end classifies the item combinationally and queues the command at
// the transfer edge; the back end, while the result queue has room, updates the
// bitmap and queues the result. Throughput: one item per cycle unless the
// result queue is full, set by the single back-end bitmap update per cycle.
// A 2-entry command queue sits between front and back, and a 2-entry result
// queue on the output: when the receiver stalls, the queues fill and full rises
// about four items later; no item is lost.
// Reset (rst_n low, synchronous): queues empty, bitmap cleared, parse idle.
// Depends on cbrp_pkg, cbrp_front, cbrp_fifo, cbrp_back.
module capability_bitmap_response_parser_top import cbrp_pkg::*; #(
  parameter int CAP_WORDS    = CAP_WORDS_DEF,
  parameter int HEADER_BYTES = HEADER_BYTES_DEF,
  parameter int MAX_COUNT    = MAX_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  output logic      full,
  input  in_item_t  in_item,
  output logic      empty,
  input  logic      pop,
  output out_item_t out_item
);

  localparam int CMD_W = $bits(cbrp_cmd_t);
  localparam int RES_W = $bits(out_item_t);

  logic      accept;
  cbrp_cmd_t front_cmd, back_cmd;
  logic      cmd_empty;
  logic      res_full;
  logic      take;
  out_item_t back_res;

  assign accept = push && !full;

  // Classify incoming items
  cbrp_front #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_COUNT    (MAX_COUNT)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_item),
    .cmd    (front_cmd)
  );

  // Decouple front from back
  cbrp_fifo #(
    .W     (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (accept),
    .wdata (front_cmd),
    .full  (full),
    .pop   (take),
    .rdata (back_cmd),
    .empty (cmd_empty)
  );

  // Apply commands to the bitmap
  cbrp_back #(
    .CAP_WORDS (CAP_WORDS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (back_cmd),
    .cmd_valid (!cmd_empty),
    .res_ready (!res_full),
    .take      (take),
    .res       (back_res)
  );

  // Hold results until the receiver takes them
  cbrp_fifo #(
    .W     (RES_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (take),
    .wdata (back_res),
    .full  (res_full),
    .pop   (pop),
    .rdata (out_item),
    .empty (empty)
  );

endmodule

// File: rtl/core/cbrp_checker.sv
// Port-level checks for the capability bitmap response parser, bound to the top.
// Depends on cbrp_pkg and capability_bitmap_response_parser_top.
module cbrp_checker import cbrp_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      push,
  input logic      full,
  input logic      empty,
  input logic      pop,
  input out_item_t out_item
);

  // Queues come out of reset empty and open
  a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !$past(rst_n) |-> (empty && !full))
    else $error("queues not clear after reset");

  // A waiting result holds until taken
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !empty && !pop) |=> (!empty && $stable(out_item)))
    else $error("waiting result changed or vanished");

  // No result appears without an input transfer shortly before
  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && $past(rst_n, 2) && $past(empty) && $past(empty, 2)
     && !$past(push && !full) && !$past(push && !full, 2)) |-> empty)
    else $error("result appeared with no input transfer");

  // Status stays within its defined codes
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> (out_item.parse_status <= ST_BAD_LEN))
    else $error("parse_status out of range");

endmodule

bind capability_bitmap_response_parser_top cbrp_checker u_checker (.*);

// File: bench/tb_capability_bitmap_response_parser_top.sv
// Self-checking testbench for capability_bitmap_response_parser_top.
// Drives a directed table and random framed responses; a local parser model predicts results.
// Depends on cbrp_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_capability_bitmap_response_parser_top;
  import cbrp_pkg::*;

  // Parser phases of the local model
  typedef enum logic [2:0] {
    FP_IDLE, FP_HEADER, FP_CODE, FP_COUNT, FP_START, FP_LEN, FP_DATA
  } frame_phase_t;

  // One stimulus row: item, and optionally a hand-typed expected result
  typedef struct packed {
    in_item_t  item;
    logic      fixed;
    out_item_t want;
  } stim_row_t;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CAP_IW = (CAP_WORDS_DEF > 1) ? $clog2(CAP_WORDS_DEF) : 1;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      push = 1'b0;
  logic      pop = 1'b0;
  in_item_t  in_item = '0;
  logic      full;
  logic      empty;
  out_item_t out_item;

  // Stimulus and expected results
  stim_row_t stim_rows[$];
  out_item_t expected_results[$];
  int        stim_idx = 0;
  int        items_accepted = 0;
  int        results_seen = 0;
  int        mismatches = 0;
  int        tx_gap = 0;
  int        rx_gap = 0;
  logic      rx_hold = 1'b0;

  // Random frame generation bookkeeping
  int        made_items;
  int        frame_bytes;
  int        cut_at;
  logic      frame_cut;

  // Local parser state
  frame_phase_t phase;
  logic [2:0]   field_count;
  logic [5:0]   segs_left;
  logic [31:0]  seg_base;
  logic [5:0]   seg_len;
  logic [5:0]   seg_byte_idx;
  logic [31:0]  cap_bitmap [CAP_WORDS_DEF];
  logic [7:0]   kept_code;
  logic [2:0]   parse_stat;

  capability_bitmap_response_parser_top u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .in_item  (in_item),
    .empty    (empty),
    .pop      (pop),
    .out_item (out_item)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- model
  function automatic void reset_parser();
    phase        = FP_IDLE;
    field_count  = '0;
    segs_left    = '0;
    seg_base     = '0;
    seg_len      = '0;
    seg_byte_idx = '0;
    kept_code    = '0;
    parse_stat   = ST_IDLE;
    for (int k = 0; k < CAP_WORDS_DEF; k++) cap_bitmap[k] = '0;
  endfunction

  // Set one capability; drop indexes past the store
  function automatic void mark_cap(logic [31:0] cap);
    if (cap < 32 * CAP_WORDS_DEF) cap_bitmap[cap[CAP_IW+4:5]][cap[4:0]] = 1'b1;
  endfunction

  function automatic void close_frame();
    cap_bitmap[0] = cap_bitmap[0] | FORCE_MASK;
    parse_stat = ST_DONE;
    phase = FP_IDLE;
  endfunction

  function automatic void advance_segment();
    if (segs_left > 0) segs_left = segs_left - 1'b1;
    if (segs_left == 0) begin
      close_frame();
    end else begin
      phase = FP_START;
      field_count = '0;
      seg_base = '0;
    end
  endfunction

  function automatic void take_byte(logic [7:0] b);
    case (phase)
      FP_HEADER: begin
        field_count = field_count + 1'b1;
        if (field_count >= HEADER_BYTES_DEF) phase = FP_CODE;
      end
      FP_CODE: begin
        kept_code = b;
        phase = FP_COUNT;
      end
      FP_COUNT: begin
        for (int k = 0; k < CAP_WORDS_DEF; k++) cap_bitmap[k] = '0;
        if (b > MAX_COUNT_DEF) begin
          parse_stat = ST_BAD_COUNT;
          phase = FP_IDLE;
        end else if (b == 0) begin
          segs_left = '0;
          close_frame();
        end else begin
          segs_left = b[5:0];
          phase = FP_START;
          field_count = '0;
          seg_base = '0;
        end
      end
      FP_START: begin
        seg_base = seg_base | ({24'd0, b} << (8 * field_count[1:0]));
        field_count = field_count + 1'b1;
        if (field_count >= START_BYTES) phase = FP_LEN;
      end
      FP_LEN: begin
        if (b > MAX_COUNT_DEF) begin
          parse_stat = ST_BAD_LEN;
          phase = FP_IDLE;
        end else if (b == 0) begin
          seg_len = '0;
          advance_segment();
        end else begin
          seg_len = b[5:0];
          seg_byte_idx = '0;
          phase = FP_DATA;
        end
      end
      FP_DATA: begin
        for (int k = 0; k < 8; k++)
          if (b[k]) mark_cap(seg_base + {23'd0, seg_byte_idx, 3'd0} + k);
        seg_byte_idx = seg_byte_idx + 1'b1;
        if (seg_byte_idx >= seg_len) advance_segment();
      end
      default: ;
    endcase
  endfunction

  // Advance the model by one item and return the result it yields
  function automatic out_item_t predict_parse(in_item_t it);
    out_item_t res;
    res = '0;
    if (it.op == OP_PUSH) begin
      if (it.frame_start) begin
        field_count = '0;
        parse_stat = ST_BUSY;
        if (HEADER_BYTES_DEF > 0) phase = FP_HEADER;
        else phase = FP_CODE;
      end
      take_byte(it.data_byte);
    end else if (it.word_index < CAP_WORDS_DEF) begin
      res.read_word = cap_bitmap[it.word_index];
    end
    res.response_code = kept_code;
    res.parse_status = parse_stat;
    return res;
  endfunction

  // ---------------------------------------------------------------- stimulus
  function automatic in_item_t push_item(logic [7:0] b, logic fs);
    in_item_t it;
    it = '0;
    it.op = OP_PUSH;
    it.data_byte = b;
    it.frame_start = fs;
    it.word_index = 3'($urandom_range(0, 7));
    return it;
  endfunction

  function automatic in_item_t read_item(logic [2:0] w);
    in_item_t it;
    it.op = OP_READ;
    it.data_byte = 8'($urandom_range(0, 255));
    it.frame_start = 1'($urandom_range(0, 1));
    it.word_index = w;
    return it;
  endfunction

  function automatic out_item_t make_result(logic [31:0] w, logic [7:0] c, logic [2:0] s);
    out_item_t r;
    r.read_word = w;
    r.response_code = c;
    r.parse_status = s;
    return r;
  endfunction

  function automatic void add_row(in_item_t it, logic fixed, out_item_t want);
    stim_row_t row;
    row.item = it;
    row.fixed = fixed;
    row.want = want;
    stim_rows.push_back(row);
  endfunction

  // Directed table: reset state, ignored bytes, restart, extremes, both errors
  task automatic build_directed();
    add_row(read_item(3'd0), 1'b1, make_result('0, 8'h00, ST_IDLE));
    add_row(push_item(8'hFF, 1'b0), 1'b1, make_result('0, 8'h00, ST_IDLE));
    add_row(push_item(8'h00, 1'b1), 1'b1, make_result('0, 8'h00, ST_BUSY));
    add_row(push_item(8'hFF, 1'b1), 1'b1, make_result('0, 8'h00, ST_BUSY));
    add_row(push_item(8'h00, 1'b0), 1'b0, '0);
    add_row(push_item(8'hA5, 1'b0), 1'b1, make_result('0, 8'hA5, ST_BUSY));
    add_row(push_item(8'h00, 1'b0), 1'b1, make_result('0, 8'hA5, ST_DONE));
    add_row(read_item(3'd0), 1'b1, make_result(FORCE_MASK, 8'hA5, ST_DONE));
    // count one above the limit
    add_row(push_item(8'h00, 1'b1), 1'b1, make_result('0, 8'hA5, ST_BUSY));
    add_row(push_item(8'h00, 1'b0), 1'b0, '0);
    add_row(push_item(8'h00, 1'b0), 1'b1, make_result('0, 8'h00, ST_BUSY));
    add_row(push_item(8'(MAX_COUNT_DEF + 1), 1'b0), 1'b1,
            make_result('0, 8'h00, ST_BAD_COUNT));
    add_row(read_item(3'd0), 1'b1, make_result('0, 8'h00, ST_BAD_COUNT));
    // start near 2^32 so the second data byte wraps to capability 0, then bad length
    add_row(push_item(8'h00, 1'b1), 1'b0, '0);
    add_row(push_item(8'h00, 1'b0), 1'b0, '0);
    add_row(push_item(8'h7E, 1'b0), 1'b0, '0);
    add_row(push_item(8'h02, 1'b0), 1'b0, '0);
    add_row(push_item(8'hF8, 1'b0), 1'b0, '0);
    add_row(push_item(8'hFF, 1'b0), 1'b0, '0);
    add_row(push_item(8'hFF, 1'b0), 1'b0, '0);
    add_row(push_item(8'hFF, 1'b0), 1'b0, '0);
    add_row(push_item(8'h02, 1'b0), 1'b0, '0);
    add_row(push_item(8'hFF, 1'b0), 1'b0, '0);
    add_row(push_item(8'h81, 1'b0), 1'b0, '0);
    for (int k = 0; k < START_BYTES; k++) add_row(push_item(8'h00, 1'b0), 1'b0, '0);
    add_row(push_item(8'hFF, 1'b0), 1'b1, make_result('0, 8'h7E, ST_BAD_LEN));
    add_row(read_item(3'd0), 1'b0, '0);
  endtask

  // Emit one frame byte, sometimes preceded by a read; stop once the frame is cut
  task automatic emit_byte(logic [7:0] b, logic fs);
    if (!frame_cut) begin
      if ($urandom_range(0, 99) < 15) begin
        add_row(read_item(3'($urandom_range(0, 7))), 1'b0, '0);
        made_items++;
      end
      add_row(push_item(b, fs), 1'b0, '0);
      made_items++;
      frame_bytes++;
      if (frame_bytes == cut_at) frame_cut = 1'b1;
    end
  endtask

  task automatic gen_frame();
    int r;
    int n_seg;
    int n_len;
    frame_bytes = 0;
    frame_cut = 1'b0;
    cut_at = ($urandom_range(0, 99) < 6) ? $urandom_range(1, 20) : -1;
    emit_byte(8'($urandom_range(0, 255)), 1'b1);
    for (int k = 1; k < HEADER_BYTES_DEF; k++) emit_byte(8'($urandom_range(0, 255)), 1'b0);
    emit_byte(8'($urandom_range(0, 255)), 1'b0);
    // segment count: mostly small, a few zero, large or bad
    r = $urandom_range(0, 99);
    if (r < 5) n_seg = $urandom_range(MAX_COUNT_DEF + 1, 255);
    else if (r < 10) n_seg = 0;
    else if (r < 93) n_seg = $urandom_range(1, 3);
    else n_seg = $urandom_range(4, MAX_COUNT_DEF);
    emit_byte(8'(n_seg), 1'b0);
    if (n_seg > MAX_COUNT_DEF) return;
    for (int s = 0; s < n_seg; s++) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        emit_byte(8'($urandom_range(0, 255)), 1'b0);
        emit_byte(8'($urandom_range(0, 1)), 1'b0);
        emit_byte(8'h00, 1'b0);
        emit_byte(8'h00, 1'b0);
      end else if (r < 85) begin
        for (int k = 0; k < START_BYTES; k++) emit_byte(8'($urandom_range(0, 255)), 1'b0);
      end else begin
        emit_byte(8'($urandom_range(8'hF8, 8'hFF)), 1'b0);
        for (int k = 1; k < START_BYTES; k++) emit_byte(8'hFF, 1'b0);
      end
      r = $urandom_range(0, 99);
      if (r < 4) n_len = $urandom_range(MAX_COUNT_DEF + 1, 255);
      else if (r < 14) n_len = 0;
      else if (r < 95) n_len = $urandom_range(1, 4);
      else n_len = $urandom_range(5, MAX_COUNT_DEF);
      emit_byte(8'(n_len), 1'b0);
      if (n_len > MAX_COUNT_DEF) return;
      for (int j = 0; j < n_len; j++) emit_byte(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  task automatic build_random();
    made_items = 0;
    while (made_items < RANDOM_ITEMS) begin
      // drop in a few stray bytes between frames
      if ($urandom_range(0, 99) < 25)
        repeat ($urandom_range(1, 3)) add_row(push_item(8'($urandom_range(0, 255)), 1'b0),
                                              1'b0, '0);
      gen_frame();
    end
  endtask

  // Gap length: mostly none or short, a few long; none in quiet stretches
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if ((items_accepted / 128) % 4 == 3) return 0;
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    $display("tb: mismatch in %s at result %0d: expected %h, got %h",
             what, results_seen, want, got);
    mismatches++;
  endtask

  task automatic check_result(out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      report_mismatch("result with nothing expected", '0, got.read_word);
    end else begin
      want = expected_results.pop_front();
      if (got.read_word !== want.read_word)
        report_mismatch("read_word", want.read_word, got.read_word);
      if (got.response_code !== want.response_code)
        report_mismatch("response_code", 32'(want.response_code), 32'(got.response_code));
      if (got.parse_status !== want.parse_status)
        report_mismatch("parse_status", 32'(want.parse_status), 32'(got.parse_status));
    end
    results_seen++;
  endtask

  // ---------------------------------------------------------------- drivers
  // Sender: predict on each transfer, hold the item while full, then idle or advance
  always @(posedge clk) begin
    if (!rst_n) begin
      push <= 1'b0;
    end else begin
      if (push && !full) begin
        if (stim_rows[stim_idx].fixed) begin
          void'(predict_parse(stim_rows[stim_idx].item));
          expected_results.push_back(stim_rows[stim_idx].want);
        end else begin
          expected_results.push_back(predict_parse(stim_rows[stim_idx].item));
        end
        stim_idx++;
        items_accepted++;
        tx_gap = pick_gap();
      end
      if (push && full) begin
        // hold the offered item
      end else if (tx_gap > 0 && !rx_hold) begin
        tx_gap--;
        push <= 1'b0;
      end else if (stim_idx < stim_rows.size()) begin
        push <= 1'b1;
        in_item <= stim_rows[stim_idx].item;
      end else begin
        push <= 1'b0;
      end
    end
  end

  // Receiver: check each transfer, then idle at random or hold off on request
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      if (pop && !empty) begin
        check_result(out_item);
        rx_gap = pick_gap();
      end
      if (rx_hold) begin
        pop <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // Stall the receiver for a long stretch so the queues fill and full rises
  initial begin
    while (items_accepted < 400) @(posedge clk);
    rx_hold <= 1'b1;
    repeat (300) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------- run control
  initial begin
    reset_parser();
    build_directed();
    build_random();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    while (stim_idx < stim_rows.size()) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: capability_bitmap_response_parser_top.f
rtl/core/cbrp_pkg.sv
rtl/core/cbrp_fifo.sv
rtl/core/cbrp_front.sv
rtl/core/cbrp_back.sv
rtl/core/capability_bitmap_response_parser_top.sv
rtl/core/cbrp_checker.sv
bench/tb_capability_bitmap_response_parser_top.sv
